/* rtl/core/bcvt_pkg.sv */
`timescale 1ns / 1ps

package bcvt_pkg;

  // Fixed field widths.
  localparam int COUNT_W    = 23;
  localparam int VEL_W      = 20;
  localparam int MISS_W     = 4;
  localparam int CFG_DATA_W = 23;
  localparam int CFG_IDX_W  = 1;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF = 11;
  localparam int FRAC_BITS_DEF  = 8;

  // Saturation value of the pixel counter and top of the miss counter.
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [MISS_W-1:0]  MISS_MAX  = {MISS_W{1'b1}};
  localparam logic [MISS_W-1:0]  MISS_ONE  = MISS_W'(1);

  // Register reset values.
  localparam logic [COUNT_W-1:0] MIN_COUNT_RST  = COUNT_W'(10);
  localparam logic [MISS_W-1:0]  MISS_LIMIT_RST = MISS_W'(10);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_COUNT  = 1'b0,
    CFG_MISS_LIMIT = 1'b1
  } cfg_idx_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic pix_acc;      // a pixel item was accepted
    logic start_cent;   // start the centroid divisions
    logic cap_cent;     // capture the centroid quotients
    logic start_vel;    // start the velocity divisions
    logic commit_hit;   // update track state for a detected frame
    logic commit_miss;  // update track state for a missed frame
    logic load_out;     // load the result item, clear the frame sums
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic detected;
    logic have_last;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

/* rtl/core/bcvt_if.sv */
`timescale 1ns / 1ps

// Pixel stream channel.
interface bcvt_pix_if #(
  parameter int COORD_BITS = bcvt_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  mask_bit;
  logic [COORD_BITS-1:0] column;
  logic [COORD_BITS-1:0] row;
  logic                  frame_end;

  modport source (output valid, mask_bit, column, row, frame_end, input ready);
  modport sink   (input valid, mask_bit, column, row, frame_end, output ready);
endinterface

// Per-frame result channel.
interface bcvt_res_if #(
  parameter int COORD_BITS = bcvt_pkg::COORD_BITS_DEF
);
  logic                                valid;
  logic                                ready;
  logic                                detected;
  logic                                has_position;
  logic [COORD_BITS-1:0]               pos_x;
  logic [COORD_BITS-1:0]               pos_y;
  logic signed [bcvt_pkg::VEL_W-1:0]   vel_x;
  logic signed [bcvt_pkg::VEL_W-1:0]   vel_y;
  logic [bcvt_pkg::MISS_W-1:0]         miss_frames;

  modport source (output valid, detected, has_position, pos_x, pos_y, vel_x, vel_y,
                  miss_frames, input ready);
  modport sink   (input valid, detected, has_position, pos_x, pos_y, vel_x, vel_y,
                  miss_frames, output ready);
endinterface

/* rtl/core/bcvt_divider.sv */
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module bcvt_divider #(
  parameter int DIVIDEND_W = 34,
  parameter int DIVISOR_W  = 23
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [DIVIDEND_W-1:0] quotient_o,
  output logic                  done_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  run_q;
  logic                  done_q;

  logic [DIVISOR_W:0] trial;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // One trial subtraction; a borrow keeps the shifted remainder without the subtraction.
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = trial - {1'b0, div_q};
  assign fits  = ~diff[DIVISOR_W];

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CNT_W'(DIVIDEND_W);
        run_q <= 1'b1;
      end else if (run_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and partial result registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (run_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

/* rtl/core/bcvt_datapath.sv */
`timescale 1ns / 1ps

module bcvt_datapath #(
  parameter int COORD_BITS = bcvt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bcvt_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bcvt_pkg::cmd_t                      cmd_i,
  output bcvt_pkg::status_t                   status_o,
  input  logic                                mask_bit_i,
  input  logic [COORD_BITS-1:0]               column_i,
  input  logic [COORD_BITS-1:0]               row_i,
  input  logic                                cfg_we_i,
  input  logic [bcvt_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bcvt_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                res_ready_i,
  output logic                                res_valid_o,
  output logic                                detected_o,
  output logic                                has_position_o,
  output logic [COORD_BITS-1:0]               pos_x_o,
  output logic [COORD_BITS-1:0]               pos_y_o,
  output logic signed [bcvt_pkg::VEL_W-1:0]   vel_x_o,
  output logic signed [bcvt_pkg::VEL_W-1:0]   vel_y_o,
  output logic [bcvt_pkg::MISS_W-1:0]         miss_frames_o
);

  localparam int COUNT_W = bcvt_pkg::COUNT_W;
  localparam int VEL_W   = bcvt_pkg::VEL_W;
  localparam int MISS_W  = bcvt_pkg::MISS_W;
  localparam int SUM_W   = COUNT_W + COORD_BITS;

  // Configuration registers.
  logic [COUNT_W-1:0] min_q;
  logic [MISS_W-1:0]  limit_q;

  // Frame accumulators.
  logic [COUNT_W-1:0] count_q;
  logic [SUM_W-1:0]   sum_x_q;
  logic [SUM_W-1:0]   sum_y_q;

  // Track state.
  logic [COORD_BITS-1:0]   last_x_q;
  logic [COORD_BITS-1:0]   last_y_q;
  logic                    have_last_q;
  logic [MISS_W-1:0]       miss_q;
  logic signed [VEL_W-1:0] vel_x_q;
  logic signed [VEL_W-1:0] vel_y_q;

  // Working registers for the current frame's evaluation.
  logic [COORD_BITS-1:0] cx_q;
  logic [COORD_BITS-1:0] cy_q;
  logic                  neg_x_q;
  logic                  neg_y_q;

  // Result item register.
  logic                    out_valid_q;
  logic                    out_det_q;
  logic                    out_has_q;
  logic [COORD_BITS-1:0]   out_x_q;
  logic [COORD_BITS-1:0]   out_y_q;
  logic signed [VEL_W-1:0] out_vx_q;
  logic signed [VEL_W-1:0] out_vy_q;
  logic [MISS_W-1:0]       out_miss_q;

  logic                    detected;
  logic                    neg_x;
  logic                    neg_y;
  logic [COORD_BITS-1:0]   mag_x;
  logic [COORD_BITS-1:0]   mag_y;
  logic                    div_start;
  logic [SUM_W-1:0]        dvd_x;
  logic [SUM_W-1:0]        dvd_y;
  logic [COUNT_W-1:0]      dvs;
  logic [SUM_W-1:0]        quo_x;
  logic [SUM_W-1:0]        quo_y;
  logic                    done_x;
  logic                    done_y;
  logic [VEL_W-1:0]        qv_x;
  logic [VEL_W-1:0]        qv_y;
  logic signed [VEL_W-1:0] new_vx;
  logic signed [VEL_W-1:0] new_vy;
  logic [MISS_W-1:0]       miss_next;

  // A frame is detected when it has set pixels and reaches the minimum.
  assign detected = (count_q != '0) && (count_q >= min_q);

  // Signed position change, as sign and magnitude.
  assign neg_x = cx_q < last_x_q;
  assign neg_y = cy_q < last_y_q;
  assign mag_x = neg_x ? (last_x_q - cx_q) : (cx_q - last_x_q);
  assign mag_y = neg_y ? (last_y_q - cy_q) : (cy_q - last_y_q);

  // The two divider lanes serve the centroid first, then the velocity.
  assign div_start = cmd_i.start_cent | cmd_i.start_vel;
  assign dvd_x = cmd_i.start_cent ? sum_x_q : (SUM_W'(mag_x) << FRAC_BITS);
  assign dvd_y = cmd_i.start_cent ? sum_y_q : (SUM_W'(mag_y) << FRAC_BITS);
  assign dvs   = cmd_i.start_cent ? count_q : COUNT_W'(miss_q);

  bcvt_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_W)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_x),
    .divisor_i  (dvs),
    .quotient_o (quo_x),
    .done_o     (done_x)
  );

  bcvt_divider #(
    .DIVIDEND_W (SUM_W),
    .DIVISOR_W  (COUNT_W)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_y),
    .divisor_i  (dvs),
    .quotient_o (quo_y),
    .done_o     (done_y)
  );

  // Velocity quotient, truncated toward zero, wrapped to the output width.
  assign qv_x   = quo_x[VEL_W-1:0];
  assign qv_y   = quo_y[VEL_W-1:0];
  assign new_vx = !have_last_q ? '0 : (neg_x_q ? -$signed(qv_x) : $signed(qv_x));
  assign new_vy = !have_last_q ? '0 : (neg_y_q ? -$signed(qv_y) : $signed(qv_y));

  // Miss counter wraps to one when it is past the limit or at its top value.
  assign miss_next = ((miss_q > limit_q) || (miss_q == bcvt_pkg::MISS_MAX)) ?
                     bcvt_pkg::MISS_ONE : (miss_q + bcvt_pkg::MISS_ONE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= bcvt_pkg::MIN_COUNT_RST;
      limit_q <= bcvt_pkg::MISS_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (bcvt_pkg::cfg_idx_e'(cfg_idx_i))
        bcvt_pkg::CFG_MIN_COUNT:  min_q   <= cfg_data_i[COUNT_W-1:0];
        bcvt_pkg::CFG_MISS_LIMIT: limit_q <= cfg_data_i[MISS_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame accumulation; a saturated count ignores further set pixels.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.load_out) begin
      count_q <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.pix_acc && mask_bit_i && (count_q != bcvt_pkg::COUNT_MAX)) begin
      count_q <= count_q + COUNT_W'(1);
      sum_x_q <= sum_x_q + SUM_W'(column_i);
      sum_y_q <= sum_y_q + SUM_W'(row_i);
    end
  end

  // Centroid capture and velocity sign capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_cent) begin
      cx_q <= quo_x[COORD_BITS-1:0];
      cy_q <= quo_y[COORD_BITS-1:0];
    end
    if (cmd_i.start_vel) begin
      neg_x_q <= neg_x;
      neg_y_q <= neg_y;
    end
  end

  // Track state update at the end of each frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_x_q    <= '0;
      last_y_q    <= '0;
      have_last_q <= 1'b0;
      miss_q      <= bcvt_pkg::MISS_ONE;
      vel_x_q     <= '0;
      vel_y_q     <= '0;
    end else if (cmd_i.commit_hit) begin
      last_x_q    <= cx_q;
      last_y_q    <= cy_q;
      have_last_q <= 1'b1;
      miss_q      <= bcvt_pkg::MISS_ONE;
      vel_x_q     <= new_vx;
      vel_y_q     <= new_vy;
    end else if (cmd_i.commit_miss) begin
      miss_q <= miss_next;
    end
  end

  // Result item register; it is handed over while the next frame streams in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_det_q  <= detected;
      out_has_q  <= have_last_q;
      out_x_q    <= last_x_q;
      out_y_q    <= last_y_q;
      out_vx_q   <= vel_x_q;
      out_vy_q   <= vel_y_q;
      out_miss_q <= miss_q;
    end
  end

  assign status_o.detected  = detected;
  assign status_o.have_last = have_last_q;
  assign status_o.div_done  = done_x;
  assign status_o.out_free  = !out_valid_q || res_ready_i;

  assign res_valid_o    = out_valid_q;
  assign detected_o     = out_det_q;
  assign has_position_o = out_has_q;
  assign pos_x_o        = out_x_q;
  assign pos_y_o        = out_y_q;
  assign vel_x_o        = out_vx_q;
  assign vel_y_o        = out_vy_q;
  assign miss_frames_o  = out_miss_q;

`ifndef SYNTHESIS
  // The miss counter never reaches zero, so the velocity divisor is safe.
  a_miss_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    miss_q != '0)
    else $error("miss counter reached zero");

  // Both divider lanes run in lockstep.
  a_lanes_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_x == done_y)
    else $error("divider lanes out of step");

  // A velocity division only follows an earlier detection.
  a_vel_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.start_vel |-> have_last_q)
    else $error("velocity division without earlier position");

  // A result item is never overwritten before it is taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || res_ready_i))
    else $error("result item overwritten");

  // A detected frame always reports a position.
  a_det_has_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_det_q) |-> out_has_q)
    else $error("detection without position");
`endif

endmodule

/* rtl/core/bcvt_ctrl.sv */
`timescale 1ns / 1ps

module bcvt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              pix_valid_i,
  input  logic              pix_frame_end_i,
  output logic              pix_ready_o,
  input  bcvt_pkg::status_t status_i,
  output bcvt_pkg::cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    ST_ACC    = 7'b0000001,
    ST_EVAL   = 7'b0000010,
    ST_CDIV   = 7'b0000100,
    ST_VSTART = 7'b0001000,
    ST_VDIV   = 7'b0010000,
    ST_COMMIT = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   accept;

  // Pixels stream in only while accumulating.
  assign pix_ready_o = (state_q == ST_ACC);
  assign accept      = pix_valid_i && pix_ready_o;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.pix_acc = accept;
    unique case (state_q)
      ST_ACC: begin
        if (accept && pix_frame_end_i) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (status_i.detected) begin
          cmd_o.start_cent = 1'b1;
          state_d          = ST_CDIV;
        end else begin
          cmd_o.commit_miss = 1'b1;
          state_d           = ST_OUT;
        end
      end
      ST_CDIV: begin
        if (status_i.div_done) begin
          cmd_o.cap_cent = 1'b1;
          state_d        = status_i.have_last ? ST_VSTART : ST_COMMIT;
        end
      end
      ST_VSTART: begin
        cmd_o.start_vel = 1'b1;
        state_d         = ST_VDIV;
      end
      ST_VDIV: begin
        if (status_i.div_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit_hit = 1'b1;
        state_d          = ST_OUT;
      end
      ST_OUT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_ACC;
        end
      end
      default: begin
        state_d = ST_ACC;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ACC;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef SYNTHESIS
  // The end of a frame is always followed by its evaluation.
  a_frame_end_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && pix_frame_end_i) |=> (state_q == ST_EVAL))
    else $error("frame end not evaluated");

  // A divider completion is only seen while a division is awaited.
  a_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == ST_CDIV || state_q == ST_VDIV))
    else $error("unexpected divider completion");

  // Each track update is followed by the result load state.
  a_commit_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit_hit || cmd_o.commit_miss) |=> (state_q == ST_OUT))
    else $error("track update not followed by result");
`endif

endmodule

/* rtl/core/blob_centroid_velocity_tracker.sv */
`timescale 1ns / 1ps

// Blob centroid and velocity tracker. Mask pixels are taken one item per
// cycle while a frame streams in; set pixels are counted and their columns
// and rows summed. After the item flagged frame_end, pixel input is held off
// while the frame is evaluated: a detected frame runs two bit-serial divider
// lanes, first for the centroid and then, when an earlier position exists,
// for the velocity. Each pass works through the sums one bit at a time and
// then reports completion. With the result register free, the next pixel
// item can be taken once the frame is evaluated: after both passes, after
// the centroid pass alone on the first detection, and straight after the
// track update for a frame without detection. One result item follows each
// frame end. It sits in an output register, so the next frame may stream
// in while it waits to be taken; the following frame end waits for that
// register to be free. Velocity is signed fixed point with FRAC_BITS
// fraction bits, truncated toward zero.
module blob_centroid_velocity_tracker #(
  parameter int COORD_BITS = bcvt_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bcvt_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  bcvt_pix_if.sink                        pix_i,
  bcvt_res_if.source                      res_o,
  input  logic                            cfg_we_i,
  input  logic [bcvt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bcvt_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bcvt_pkg::cmd_t    cmd;
  bcvt_pkg::status_t status;

  bcvt_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix_valid_i     (pix_i.valid),
    .pix_frame_end_i (pix_i.frame_end),
    .pix_ready_o     (pix_i.ready),
    .status_i        (status),
    .cmd_o           (cmd)
  );

  bcvt_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mask_bit_i     (pix_i.mask_bit),
    .column_i       (pix_i.column),
    .row_i          (pix_i.row),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .res_ready_i    (res_o.ready),
    .res_valid_o    (res_o.valid),
    .detected_o     (res_o.detected),
    .has_position_o (res_o.has_position),
    .pos_x_o        (res_o.pos_x),
    .pos_y_o        (res_o.pos_y),
    .vel_x_o        (res_o.vel_x),
    .vel_y_o        (res_o.vel_y),
    .miss_frames_o  (res_o.miss_frames)
  );

endmodule

/* test/blob_centroid_velocity_tracker_test.sv */
`timescale 1ns / 1ps

module blob_centroid_velocity_tracker_test;

  localparam int COORD_BITS   = bcvt_pkg::COORD_BITS_DEF;
  localparam int FRAC_BITS    = bcvt_pkg::FRAC_BITS_DEF;
  localparam int COUNT_W      = bcvt_pkg::COUNT_W;
  localparam int VEL_W        = bcvt_pkg::VEL_W;
  localparam int MISS_W       = bcvt_pkg::MISS_W;
  localparam int CFG_DATA_W   = bcvt_pkg::CFG_DATA_W;
  localparam int SUM_W        = COUNT_W + COORD_BITS;
  localparam int CLK_PERIOD   = 12;
  localparam int TAIL_CYCLES  = 100;
  localparam int LIMIT_CYCLES = 1_000_000;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam coord_t COORD_MAX = '1;

  typedef struct {
    logic   mask_bit;
    coord_t column;
    coord_t row;
    logic   frame_end;
  } pixel_t;

  typedef struct {
    logic                    detected;
    logic                    has_position;
    coord_t                  pos_x;
    coord_t                  pos_y;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic [MISS_W-1:0]       miss_frames;
  } track_result_t;

  // Tracks the blob state alongside the block and keeps the frame results
  // that are still owed, oldest first.
  class tracker_scoreboard;
    logic [COUNT_W-1:0]      min_count;
    logic [MISS_W-1:0]       miss_limit;
    logic [COUNT_W-1:0]      pixel_count;
    logic [SUM_W-1:0]        column_sum;
    logic [SUM_W-1:0]        row_sum;
    coord_t                  last_x;
    coord_t                  last_y;
    logic                    have_last;
    logic [MISS_W-1:0]       miss_count;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    track_result_t           frame_results_q[$];
    int                      errors;

    function new();
      min_count   = bcvt_pkg::MIN_COUNT_RST;
      miss_limit  = bcvt_pkg::MISS_LIMIT_RST;
      pixel_count = '0;
      column_sum  = '0;
      row_sum     = '0;
      last_x      = '0;
      last_y      = '0;
      have_last   = 1'b0;
      miss_count  = bcvt_pkg::MISS_ONE;
      vel_x       = '0;
      vel_y       = '0;
      errors      = 0;
    endfunction

    function void write_register(bcvt_pkg::cfg_idx_e idx, cfg_data_t data);
      case (idx)
        bcvt_pkg::CFG_MIN_COUNT:  min_count = data[COUNT_W-1:0];
        bcvt_pkg::CFG_MISS_LIMIT: miss_limit = data[MISS_W-1:0];
        default: ;
      endcase
    endfunction

    // Position change scaled by the fraction bits, divided by the miss count
    // and truncated toward zero; only the low bits of the result are kept.
    function logic signed [VEL_W-1:0] step_velocity(coord_t now, coord_t prev,
                                                    logic [MISS_W-1:0] frames);
      longint diff;
      longint mag;
      longint quo;
      diff = longint'(now) - longint'(prev);
      mag  = (diff < 0) ? -diff : diff;
      quo  = (mag <<< FRAC_BITS) / longint'(frames);
      if (diff < 0) quo = -quo;
      return quo[VEL_W-1:0];
    endfunction

    function void note_pixel(pixel_t p);
      logic hit;
      coord_t cx;
      coord_t cy;
      // A set pixel counts unless the counter is already full.
      if (p.mask_bit && pixel_count != bcvt_pkg::COUNT_MAX) begin
        pixel_count = pixel_count + COUNT_W'(1);
        column_sum  = column_sum + SUM_W'(p.column);
        row_sum     = row_sum + SUM_W'(p.row);
      end
      if (!p.frame_end) return;

      // Frame end: decide detection and update the track.
      hit = (pixel_count != '0) && (pixel_count >= min_count);
      if (hit) begin
        cx = coord_t'(column_sum / SUM_W'(pixel_count));
        cy = coord_t'(row_sum / SUM_W'(pixel_count));
        if (have_last) begin
          vel_x = step_velocity(cx, last_x, miss_count);
          vel_y = step_velocity(cy, last_y, miss_count);
        end else begin
          vel_x = '0;
          vel_y = '0;
        end
        last_x     = cx;
        last_y     = cy;
        have_last  = 1'b1;
        miss_count = bcvt_pkg::MISS_ONE;
      end else if (miss_count > miss_limit || miss_count == bcvt_pkg::MISS_MAX) begin
        miss_count = bcvt_pkg::MISS_ONE;
      end else begin
        miss_count = miss_count + bcvt_pkg::MISS_ONE;
      end
      pixel_count = '0;
      column_sum  = '0;
      row_sum     = '0;
      frame_results_q.push_back(track_result_t'{hit, have_last, last_x, last_y,
                                                vel_x, vel_y, miss_count});
    endfunction

    function void compare_field(string name, logic signed [31:0] want,
                                logic signed [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(track_result_t got);
      track_result_t want;
      if (frame_results_q.size() == 0) begin
        $error("result item arrived with no frame result pending");
        errors++;
        return;
      end
      want = frame_results_q.pop_front();
      compare_field("detected", 32'(want.detected), 32'(got.detected));
      compare_field("has_position", 32'(want.has_position), 32'(got.has_position));
      compare_field("pos_x", 32'(want.pos_x), 32'(got.pos_x));
      compare_field("pos_y", 32'(want.pos_y), 32'(got.pos_y));
      compare_field("vel_x", 32'(want.vel_x), 32'(got.vel_x));
      compare_field("vel_y", 32'(want.vel_y), 32'(got.vel_y));
      compare_field("miss_frames", 32'(want.miss_frames), 32'(got.miss_frames));
    endfunction

    function int pending();
      return frame_results_q.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  bcvt_pkg::cfg_idx_e   cfg_idx_i;
  cfg_data_t            cfg_data_i;
  int                   send_idle_pct;
  int                   stall_pct;
  tracker_scoreboard    sb;

  bcvt_pix_if #(.COORD_BITS(COORD_BITS)) pix ();
  bcvt_res_if #(.COORD_BITS(COORD_BITS)) res ();

  blob_centroid_velocity_tracker #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_i     (pix),
    .res_o     (res),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // The result receiver stalls at random at the rate of the current phase.
  always @(posedge clk_i) begin
    res.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every accepted pixel item feeds the tracking state.
  always @(posedge clk_i) begin
    if (rst_ni && pix.valid && pix.ready) begin
      sb.note_pixel(pixel_t'{pix.mask_bit, pix.column, pix.row, pix.frame_end});
    end
  end

  // Every accepted result item is checked against the oldest frame result.
  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      sb.check_result(track_result_t'{res.detected, res.has_position, res.pos_x,
                                      res.pos_y, res.vel_x, res.vel_y,
                                      res.miss_frames});
    end
  end

  // Offers one pixel item, with random idle cycles ahead of it, and returns
  // at the edge where it is taken.
  task automatic send_pixel(logic mask, coord_t col, coord_t row, logic fe);
    while ($urandom_range(99) < send_idle_pct) begin
      pix.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix.valid     <= 1'b1;
    pix.mask_bit  <= mask;
    pix.column    <= col;
    pix.row       <= row;
    pix.frame_end <= fe;
    do @(posedge clk_i); while (!pix.ready);
  endtask

  // Stops sending and waits until every frame result has been taken.
  task automatic wait_drained(int tail);
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (tail) @(posedge clk_i);
  endtask

  task automatic write_config(cfg_data_t min_count, cfg_data_t limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= bcvt_pkg::CFG_MIN_COUNT;
    cfg_data_i <= min_count;
    sb.write_register(bcvt_pkg::CFG_MIN_COUNT, min_count);
    @(posedge clk_i);
    cfg_idx_i  <= bcvt_pkg::CFG_MISS_LIMIT;
    cfg_data_i <= limit;
    sb.write_register(bcvt_pkg::CFG_MISS_LIMIT, limit);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random whole frames: runs of empty frames to walk the miss counter, and
  // blobs of varied length and density, either spread over the whole frame
  // or packed into a small window so that centroids move far between frames.
  task automatic send_frames(int n_items, bit pause_midway);
    int     sent;
    int     streak;
    int     len;
    int     density;
    bit     narrow;
    bit     paused;
    coord_t base_x;
    coord_t base_y;
    coord_t cx;
    coord_t cy;
    sent   = 0;
    paused = 1'b0;
    while (sent < n_items) begin
      if (pause_midway && !paused && sent >= n_items / 2) begin
        paused = 1'b1;
        wait_drained(0);
      end
      if ($urandom_range(9) < 2) begin
        streak = $urandom_range(1, 16);
        repeat (streak) send_pixel(1'b0, coord_t'($urandom), coord_t'($urandom), 1'b1);
        sent += streak;
      end else begin
        len     = ($urandom_range(3) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
        density = $urandom_range(100);
        narrow  = 1'($urandom_range(1));
        base_x  = coord_t'($urandom_range(COORD_MAX - 15));
        base_y  = coord_t'($urandom_range(COORD_MAX - 15));
        for (int i = 0; i < len; i++) begin
          if (narrow) begin
            cx = base_x + coord_t'($urandom_range(15));
            cy = base_y + coord_t'($urandom_range(15));
          end else begin
            cx = coord_t'($urandom);
            cy = coord_t'($urandom);
          end
          send_pixel($urandom_range(99) < density, cx, cy, i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  task automatic run_phase(cfg_data_t min_count, cfg_data_t limit, int idle_pct,
                           int recv_pct, int n_items, bit pause_midway);
    write_config(min_count, limit);
    send_idle_pct = idle_pct;
    stall_pct     = recv_pct;
    send_frames(n_items, pause_midway);
    wait_drained(TAIL_CYCLES);
  endtask

  initial begin
    sb            = new();
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = bcvt_pkg::CFG_MIN_COUNT;
    cfg_data_i    = '0;
    pix.valid     = 1'b0;
    pix.mask_bit  = 1'b0;
    pix.column    = '0;
    pix.row       = '0;
    pix.frame_end = 1'b0;
    res.ready     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed frames: an empty frame, single-pixel detections at opposite
    // corners for the largest velocities both ways, a run of misses that
    // stretches the divisor, a set pixel carried by the frame end item, and
    // a centroid that truncates.
    write_config(CFG_DATA_W'(1), CFG_DATA_W'(14));
    send_pixel(1'b0, COORD_MAX, '0, 1'b1);
    send_pixel(1'b1, '0, '0, 1'b1);
    send_pixel(1'b1, COORD_MAX, COORD_MAX, 1'b1);
    send_pixel(1'b1, '0, '0, 1'b1);
    repeat (3) send_pixel(1'b0, '0, COORD_MAX, 1'b1);
    send_pixel(1'b0, COORD_MAX, COORD_MAX, 1'b0);
    send_pixel(1'b1, COORD_MAX, '0, 1'b1);
    send_pixel(1'b1, coord_t'(1), coord_t'(2), 1'b0);
    send_pixel(1'b1, coord_t'(2), coord_t'(3), 1'b0);
    send_pixel(1'b1, coord_t'(4), coord_t'(4), 1'b1);
    wait_drained(TAIL_CYCLES);

    // A zero minimum must still reject an empty frame; the low miss limit
    // makes the counter wrap on the second miss.
    write_config(CFG_DATA_W'(0), CFG_DATA_W'(1));
    send_pixel(1'b0, '0, '0, 1'b1);
    send_pixel(1'b0, COORD_MAX, COORD_MAX, 1'b1);
    wait_drained(TAIL_CYCLES);

    // Random phases under varied settings and flow control.
    run_phase(CFG_DATA_W'(1), CFG_DATA_W'(14), 0, 0, 120, 1'b0);
    run_phase(bcvt_pkg::MIN_COUNT_RST, CFG_DATA_W'(bcvt_pkg::MISS_LIMIT_RST), 54, 0,
              120, 1'b1);
    run_phase(CFG_DATA_W'(0), CFG_DATA_W'(1), 0, 54, 120, 1'b0);
    run_phase({COUNT_W{1'b1}}, CFG_DATA_W'(15), 27, 27, 120, 1'b0);
    run_phase(CFG_DATA_W'(3), CFG_DATA_W'(0), 0, 0, 120, 1'b0);
    run_phase(CFG_DATA_W'(2), CFG_DATA_W'(5), 27, 27, 120, 1'b0);
    run_phase(CFG_DATA_W'(1), CFG_DATA_W'(2), 0, 54, 120, 1'b0);

    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Hard stop for a hung run.
  initial begin
    #(LIMIT_CYCLES * CLK_PERIOD);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
